// File: hw/rtl/ddo_pkg.sv
// Shared constants, command types and the quarter-wave sine table for the odometry block.
package ddo_pkg;

  // Encoder and table geometry.
  localparam int ENC_W     = 12;
  localparam int TBL_BITS  = 10;
  localparam int TBL_N     = 1 << TBL_BITS;
  localparam int STEP_W    = ENC_W + 1;
  localparam int WORK_W    = ENC_W + 2;
  localparam int MAG_W     = 31;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ENC_HALF  = 1 << (ENC_W - 1);
  localparam int ENC_FULL  = 1 << ENC_W;
  localparam logic signed [WORK_W-1:0] ENC_HALF_S = WORK_W'(ENC_HALF);
  localparam logic signed [WORK_W-1:0] ENC_FULL_S = WORK_W'(ENC_FULL);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

  // Split point of the distance product for the two partial products.
  localparam int M_W  = STEP_W + 32;
  localparam int LO_W = 25;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_METRES_PER_TICK = 3'd0,
    CFG_TURN_PER_TICK   = 3'd1,
    CFG_START_X         = 3'd2,
    CFG_START_Y         = 3'd3,
    CFG_START_HEADING   = 3'd4
  } cfg_idx_t;

  // Operand choice for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_DIST = 3'd0,
    MUL_HI_C = 3'd1,
    MUL_LO_C = 3'd2,
    MUL_HI_S = 3'd3,
    MUL_LO_S = 3'd4,
    MUL_TURN = 3'd5
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     rom_cos;
    logic     cap_m;
    logic     cap_s;
    logic     cap_hi;
    logic     make_r;
    logic     add_x;
    logic     add_y;
    logic     add_th;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic will_update;
  } stat_t;

  typedef logic [MAG_W-1:0] rom_t [0:TBL_N];

  // Builds the quarter-wave sine table in Q30 from a 17th-order Taylor sum.
  function automatic rom_t build_quarter();
    rom_t              t;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] sum;
    for (int j = 0; j <= TBL_N; j++) begin
      x    = (64'(j) * HALF_PI_Q30 + 64'(TBL_N / 2)) >> TBL_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1: term = term / 64'd6;
          2: term = term / 64'd20;
          3: term = term / 64'd42;
          4: term = term / 64'd72;
          5: term = term / 64'd110;
          6: term = term / 64'd156;
          7: term = term / 64'd210;
          default: term = term / 64'd272;
        endcase
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      t[j] = MAG_W'(sum);
    end
    return t;
  endfunction

  // Folds an angle difference into the half-turn window.
  function automatic logic signed [WORK_W-1:0] unwrap(input logic signed [WORK_W-1:0] d);
    logic signed [WORK_W-1:0] r;
    r = d;
    if (d > ENC_HALF_S) begin
      r = d - ENC_FULL_S;
    end else if (d < -ENC_HALF_S) begin
      r = d + ENC_FULL_S;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ddo_sine_rom.sv
// Quarter-wave sine lookup with registered magnitude and sign.
module ddo_sine_rom (
  input  logic                      clk,
  input  logic [31:0]               angle,
  output logic [ddo_pkg::MAG_W-1:0] mag,
  output logic                      neg
);

  localparam ddo_pkg::rom_t QTAB = ddo_pkg::build_quarter();

  logic [ddo_pkg::TBL_BITS+1:0] idx;
  logic [ddo_pkg::TBL_BITS-1:0] k;
  logic [ddo_pkg::TBL_BITS:0]   addr;

  // Quadrant folding: odd quadrants read the table backwards.
  always_comb begin
    idx  = angle[31:30-ddo_pkg::TBL_BITS];
    k    = idx[ddo_pkg::TBL_BITS-1:0];
    addr = idx[ddo_pkg::TBL_BITS] ?
           (ddo_pkg::TBL_BITS+1)'(ddo_pkg::TBL_N) - {1'b0, k} : {1'b0, k};
  end

  // Registered table read.
  always_ff @(posedge clk) begin
    mag <= QTAB[addr];
    neg <= idx[ddo_pkg::TBL_BITS+1];
  end

endmodule

// File: hw/rtl/ddo_datapath.sv
// Odometry datapath: step unwrap, tick totals, shared multiplier and pose update.
module ddo_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  ddo_pkg::cmd_t                  cmd,
  output ddo_pkg::stat_t                 stat,
  input  logic                           cfg_we,
  input  logic [ddo_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           reading_valid,
  input  logic [ddo_pkg::ENC_W-1:0]      left_raw,
  input  logic                           left_good,
  input  logic [ddo_pkg::ENC_W-1:0]      right_raw,
  input  logic                           right_good,
  output logic                           accepted,
  output logic [ddo_pkg::STEP_W-1:0]     left_step,
  output logic [ddo_pkg::STEP_W-1:0]     right_step,
  output logic [31:0]                    left_total,
  output logic [31:0]                    right_total,
  output logic [63:0]                    pose_x,
  output logic [63:0]                    pose_y,
  output logic [31:0]                    heading
);

  localparam int W = ddo_pkg::WORK_W;

  // Architectural state.
  logic                       primed;
  logic [ddo_pkg::ENC_W-1:0]  prev_left;
  logic [ddo_pkg::ENC_W-1:0]  prev_right;
  logic [31:0]                sum_left;
  logic [31:0]                sum_right;
  logic [63:0]                pos_x;
  logic [63:0]                pos_y;
  logic [31:0]                theta;
  logic [31:0]                metres_per_tick;
  logic [31:0]                turn_per_tick;

  // Working registers of one update.
  logic                       upd;
  logic signed [W-1:0]        dl;
  logic signed [W-1:0]        dr;
  logic signed [W-1:0]        s_sum;
  logic signed [W-1:0]        s_diff;
  logic [63:0]                p;
  logic [ddo_pkg::M_W-1:0]    m;
  logic [63:0]                hi;
  logic [63:0]                r;
  logic [ddo_pkg::MAG_W-1:0]  c_mag;
  logic                       c_neg;
  logic [ddo_pkg::MAG_W-1:0]  s_mag;
  logic                       s_neg;

  logic [ddo_pkg::ENC_W-1:0]  la_eff;
  logic [ddo_pkg::ENC_W-1:0]  ra_eff;
  logic signed [W-1:0]        dl_next;
  logic signed [W-1:0]        dr_next;
  logic [W-2:0]               s_abs;
  logic [31:0]                mul_a;
  logic [31:0]                mul_b;
  logic [63:0]                r_next;
  logic [63:0]                r_neg;
  logic [31:0]                rom_angle;
  logic [ddo_pkg::MAG_W-1:0]  rom_mag;
  logic                       rom_neg;

  ddo_sine_rom u_rom (
    .clk   (clk),
    .angle (rom_angle),
    .mag   (rom_mag),
    .neg   (rom_neg)
  );

  assign rom_angle = theta + (cmd.rom_cos ? 32'h4000_0000 : 32'h0);

  // Step unwrap from the incoming request; a failed wheel keeps its angle.
  always_comb begin
    la_eff  = left_good  ? left_raw  : prev_left;
    ra_eff  = right_good ? right_raw : prev_right;
    dl_next = ddo_pkg::unwrap($signed({2'b00, prev_left}) - $signed({2'b00, la_eff}));
    dr_next = ddo_pkg::unwrap($signed({2'b00, ra_eff}) - $signed({2'b00, prev_right}));
    stat.will_update = reading_valid && primed;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    s_abs = s_sum[W-1] ? (W-1)'(-s_sum) : (W-1)'(s_sum);
    case (cmd.mul_sel)
      ddo_pkg::MUL_DIST: begin
        mul_a = 32'(s_abs);
        mul_b = metres_per_tick;
      end
      ddo_pkg::MUL_HI_C: begin
        mul_a = 32'(p[ddo_pkg::M_W-1:ddo_pkg::LO_W]);
        mul_b = 32'(rom_mag);
      end
      ddo_pkg::MUL_LO_C: begin
        mul_a = 32'(m[ddo_pkg::LO_W-1:0]);
        mul_b = 32'(c_mag);
      end
      ddo_pkg::MUL_HI_S: begin
        mul_a = 32'(m[ddo_pkg::M_W-1:ddo_pkg::LO_W]);
        mul_b = 32'(s_mag);
      end
      ddo_pkg::MUL_LO_S: begin
        mul_a = 32'(m[ddo_pkg::LO_W-1:0]);
        mul_b = 32'(s_mag);
      end
      ddo_pkg::MUL_TURN: begin
        mul_a = 32'(s_diff);
        mul_b = turn_per_tick;
      end
      default: begin
        mul_a = 32'h0;
        mul_b = 32'h0;
      end
    endcase
  end

  // Recombine the two partial products: floor(m * mag / 2^31).
  always_comb begin
    r_next = (hi >> 6) + ((({58'h0, hi[5:0]} << ddo_pkg::LO_W) + p) >> 31);
    r_neg  = 64'h0 - r;
  end

  // Multiplier and working registers.
  always_ff @(posedge clk) begin
    p <= {32'h0, mul_a} * {32'h0, mul_b};
    if (cmd.cap_m) begin
      m     <= p[ddo_pkg::M_W-1:0];
      c_mag <= rom_mag;
      c_neg <= rom_neg;
    end
    if (cmd.cap_s) begin
      s_mag <= rom_mag;
      s_neg <= rom_neg;
    end
    if (cmd.cap_hi) begin
      hi <= p;
    end
    if (cmd.make_r) begin
      r <= r_next;
    end
  end

  // State updates and configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed          <= 1'b0;
      prev_left       <= '0;
      prev_right      <= '0;
      sum_left        <= '0;
      sum_right       <= '0;
      pos_x           <= '0;
      pos_y           <= '0;
      theta           <= '0;
      metres_per_tick <= '0;
      turn_per_tick   <= '0;
      upd             <= 1'b0;
      dl              <= '0;
      dr              <= '0;
      s_sum           <= '0;
      s_diff          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ddo_pkg::CFG_METRES_PER_TICK: metres_per_tick <= cfg_data[31:0];
          ddo_pkg::CFG_TURN_PER_TICK:   turn_per_tick   <= cfg_data[31:0];
          ddo_pkg::CFG_START_X:         pos_x           <= cfg_data;
          ddo_pkg::CFG_START_Y:         pos_y           <= cfg_data;
          ddo_pkg::CFG_START_HEADING:   theta           <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        upd <= stat.will_update;
        if (stat.will_update) begin
          dl         <= dl_next;
          dr         <= dr_next;
          s_sum      <= dl_next + dr_next;
          s_diff     <= dr_next - dl_next;
          sum_left   <= sum_left  + 32'(dl_next);
          sum_right  <= sum_right + 32'(dr_next);
          prev_left  <= la_eff;
          prev_right <= ra_eff;
        end else begin
          dl     <= '0;
          dr     <= '0;
          s_sum  <= '0;
          s_diff <= '0;
          if (reading_valid && left_good && right_good) begin
            prev_left  <= left_raw;
            prev_right <= right_raw;
            primed     <= 1'b1;
          end
        end
      end
      if (cmd.add_x) begin
        pos_x <= pos_x + ((s_sum[W-1] ^ c_neg) ? r_neg : r);
      end
      if (cmd.add_y) begin
        pos_y <= pos_y + ((s_sum[W-1] ^ s_neg) ? r_neg : r);
      end
      if (cmd.add_th) begin
        theta <= theta + p[31:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted    <= upd;
      left_step   <= ddo_pkg::STEP_W'(dl);
      right_step  <= ddo_pkg::STEP_W'(dr);
      left_total  <= sum_left;
      right_total <= sum_right;
      pose_x      <= pos_x;
      pose_y      <= pos_y;
      heading     <= theta;
    end
  end

endmodule

// File: hw/rtl/ddo_ctrl.sv
// Odometry controller: sequences one request through the shared multiplier.
module ddo_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  ddo_pkg::stat_t stat,
  output ddo_pkg::cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_M    = 9'b000000010,
    S_HX   = 9'b000000100,
    S_LX   = 9'b000001000,
    S_RX   = 9'b000010000,
    S_AX   = 9'b000100000,
    S_RY   = 9'b001000000,
    S_AY   = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = ddo_pkg::MUL_DIST;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = stat.will_update ? S_M : S_DONE;
        end
      end
      S_M: begin
        cmd.rom_cos = 1'b1;
        state_next  = S_HX;
      end
      S_HX: begin
        cmd.mul_sel = ddo_pkg::MUL_HI_C;
        cmd.cap_m   = 1'b1;
        state_next  = S_LX;
      end
      S_LX: begin
        cmd.mul_sel = ddo_pkg::MUL_LO_C;
        cmd.cap_hi  = 1'b1;
        cmd.cap_s   = 1'b1;
        state_next  = S_RX;
      end
      S_RX: begin
        cmd.mul_sel = ddo_pkg::MUL_HI_S;
        cmd.make_r  = 1'b1;
        state_next  = S_AX;
      end
      S_AX: begin
        cmd.mul_sel = ddo_pkg::MUL_LO_S;
        cmd.add_x   = 1'b1;
        cmd.cap_hi  = 1'b1;
        state_next  = S_RY;
      end
      S_RY: begin
        cmd.mul_sel = ddo_pkg::MUL_TURN;
        cmd.make_r  = 1'b1;
        state_next  = S_AY;
      end
      S_AY: begin
        cmd.add_y  = 1'b1;
        cmd.add_th = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // The pose sequence always finishes in the result state.
  a_ay_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_AY) |=> (state == S_DONE))
    else $error("pose sequence did not reach the result state");

  // A request that updates nothing skips the multiplier sequence.
  a_skip: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !stat.will_update) |=> (state == S_DONE))
    else $error("non-updating request entered the multiplier sequence");

  // A new result only appears after the result state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside the result state");

endmodule

// File: hw/rtl/differential_drive_odometry.sv
// Top level of the differential-drive odometry block.
//
// Each input request on the s_axis channel is one reading of the two wheel
// encoders; tuser carries the reading-valid flag. Every request yields exactly
// one result on the m_axis channel with the steps, tick totals and pose.
// A request that updates odometry has its result computed in turn: one shared
// 32x32 multiplier is used six times (distance, two partial products each for
// x and y, heading change), and the sine table read is registered. A request
// that does not update goes straight to the result state. One request is
// worked on at a time; the next is taken in the cycle after the result is
// loaded, while that result may still be waiting in the output register.
// When the receiver stalls, a finished result holds in the output register
// and the next request stops in its result state until the register frees.
// Reset clears the pose, totals, heading, gains and the primed flag; the
// first good reading afterwards only records the angles. Configuration
// writes are taken in any cycle and must come only while the block is idle.
module differential_drive_odometry (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // left_raw[11:0], left_good[12], right_raw[24:13], right_good[25], zero pad
  input  logic [31:0]                    s_axis_tdata,
  // reading_valid[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // left_step[12:0], right_step[25:13], left_total[57:26], right_total[89:58],
  // pose_x[153:90], pose_y[217:154], heading[249:218], zero pad
  output logic [255:0]                   m_axis_tdata,
  // accepted[0]
  output logic                           m_axis_tuser,
  input  logic                           cfg_we,
  input  logic [ddo_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data
);

  ddo_pkg::cmd_t  cmd;
  ddo_pkg::stat_t stat;

  logic [ddo_pkg::STEP_W-1:0] left_step;
  logic [ddo_pkg::STEP_W-1:0] right_step;
  logic [31:0]                left_total;
  logic [31:0]                right_total;
  logic [63:0]                pose_x;
  logic [63:0]                pose_y;
  logic [31:0]                heading;

  ddo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ddo_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .reading_valid (s_axis_tuser),
    .left_raw      (s_axis_tdata[11:0]),
    .left_good     (s_axis_tdata[12]),
    .right_raw     (s_axis_tdata[24:13]),
    .right_good    (s_axis_tdata[25]),
    .accepted      (m_axis_tuser),
    .left_step     (left_step),
    .right_step    (right_step),
    .left_total    (left_total),
    .right_total   (right_total),
    .pose_x        (pose_x),
    .pose_y        (pose_y),
    .heading       (heading)
  );

  // Result packing, first field in the lowest bits.
  assign m_axis_tdata = {6'b0, heading, pose_y, pose_x, right_total, left_total,
                         right_step, left_step};

endmodule

// File: tb/sv/tb_differential_drive_odometry.sv
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 100ps

module tb_differential_drive_odometry;

  // Expected contents of one odometry result.
  typedef struct {
    logic               accepted;
    logic [12:0]        left_step;
    logic [12:0]        right_step;
    logic [31:0]        left_total;
    logic [31:0]        right_total;
    logic [63:0]        pose_x;
    logic [63:0]        pose_y;
    logic [31:0]        heading;
  } odo_result_t;

  // Predicts odometry results and compares them with what the block reports.
  class odometry_scoreboard;
    logic [31:0] gain_dist, gain_turn;
    logic        primed;
    logic [11:0] last_left, last_right;
    logic [31:0] ticks_left, ticks_right;
    logic [63:0] px, py;
    logic [31:0] theta;
    logic [63:0] sine_rom [0:1024];
    odo_result_t pending [$];
    int          errors;

    function new();
      logic [63:0] x, x2, term;
      longint sum;
      for (int j = 0; j <= 1024; j++) begin
        x = (64'(j) * 64'd1686629713 + 64'd512) >> 10;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 8; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > 64'sd1073741824) sum = 64'sd1073741824;
        sine_rom[j] = sum;
      end
      clear();
    endfunction

    function void clear();
      gain_dist = 0; gain_turn = 0; primed = 0;
      last_left = 0; last_right = 0; ticks_left = 0; ticks_right = 0;
      px = 0; py = 0; theta = 0; errors = 0;
    endfunction

    function void write_reg(ddo_pkg::cfg_idx_t idx, logic [63:0] value);
      case (idx)
        ddo_pkg::CFG_METRES_PER_TICK: gain_dist = value[31:0];
        ddo_pkg::CFG_TURN_PER_TICK:   gain_turn = value[31:0];
        ddo_pkg::CFG_START_X:         px = value;
        ddo_pkg::CFG_START_Y:         py = value;
        ddo_pkg::CFG_START_HEADING:   theta = value[31:0];
        default: ;
      endcase
    endfunction

    function longint sine_of(logic [31:0] ang);
      logic [11:0] idx;
      logic [9:0]  k;
      longint      mag;
      idx = ang[31:20];
      k = idx[9:0];
      mag = idx[10] ? sine_rom[1024 - int'(k)] : sine_rom[k];
      return idx[11] ? -mag : mag;
    endfunction

    // Signed travel times a Q30 direction, scaled down by 2^31.
    function logic [63:0] travel(int steps, longint dir);
      logic [127:0] prod;
      logic [63:0]  mag;
      if (steps == 0 || dir == 0) return 0;
      prod = 128'(steps < 0 ? -steps : steps) * 128'(gain_dist)
             * 128'(dir < 0 ? -dir : dir);
      mag = prod[94:31];
      return ((steps < 0) != (dir < 0)) ? -mag : mag;
    endfunction

    function int fold(int d);
      if (d > 2048) return d - 4096;
      if (d < -2048) return d + 4096;
      return d;
    endfunction

    function void note_reading(logic valid, logic [11:0] la, logic lg,
                               logic [11:0] ra, logic rg);
      odo_result_t r;
      int dl, dr;
      logic [63:0] dx, dy;
      dl = 0; dr = 0;
      r.accepted = 0;
      if (valid && !primed) begin
        if (lg && rg) begin
          last_left = la; last_right = ra; primed = 1;
        end
      end else if (valid) begin
        if (!lg) la = last_left;
        if (!rg) ra = last_right;
        dl = fold(int'(last_left) - int'(la));
        dr = fold(int'(ra) - int'(last_right));
        ticks_left += 32'(dl);
        ticks_right += 32'(dr);
        dx = travel(dl + dr, sine_of(theta + 32'h4000_0000));
        dy = travel(dl + dr, sine_of(theta));
        px += dx; py += dy;
        theta += 32'(dr - dl) * gain_turn;
        last_left = la; last_right = ra;
        r.accepted = 1;
      end
      r.left_step = 13'(dl); r.right_step = 13'(dr);
      r.left_total = ticks_left; r.right_total = ticks_right;
      r.pose_x = px; r.pose_y = py; r.heading = theta;
      pending.push_back(r);
    endfunction

    function void check_result(logic [255:0] data, logic acc);
      odo_result_t e;
      if (pending.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (acc !== e.accepted) begin
        $error("accepted: expected %0d, got %0d", e.accepted, acc); errors++;
      end
      if (data[12:0] !== e.left_step) begin
        $error("left_step: expected %h, got %h", e.left_step, data[12:0]); errors++;
      end
      if (data[25:13] !== e.right_step) begin
        $error("right_step: expected %h, got %h", e.right_step, data[25:13]); errors++;
      end
      if (data[57:26] !== e.left_total) begin
        $error("left_total: expected %h, got %h", e.left_total, data[57:26]); errors++;
      end
      if (data[89:58] !== e.right_total) begin
        $error("right_total: expected %h, got %h", e.right_total, data[89:58]); errors++;
      end
      if (data[153:90] !== e.pose_x) begin
        $error("pose_x: expected %h, got %h", e.pose_x, data[153:90]); errors++;
      end
      if (data[217:154] !== e.pose_y) begin
        $error("pose_y: expected %h, got %h", e.pose_y, data[217:154]); errors++;
      end
      if (data[249:218] !== e.heading) begin
        $error("heading: expected %h, got %h", e.heading, data[249:218]); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = 0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [255:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we = 0;
  logic [ddo_pkg::CFG_ADDR_W-1:0] cfg_addr = 0;
  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  odometry_scoreboard odo = new();

  differential_drive_odometry dut (.*);

  always #5 clk = ~clk;

  // Cycle limit: a run that does not finish in time is reported as failed.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random back-pressure, checks each accepted result.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) odo.check_result(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // One register write, after which the write enable is driven low again.
  task automatic write_reg(ddo_pkg::cfg_idx_t idx, logic [63:0] value);
    cfg_we <= 1; cfg_addr <= idx; cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    odo.write_reg(idx, value);
    @(posedge clk);
  endtask

  // Waits for all results, then the latency of an update, before a write.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (odo.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Presents one request and waits until it is taken; the valid stays high
  // until the next request or an idle cycle replaces it.
  task automatic send_reading(logic valid, logic [11:0] la, logic lg,
                              logic [11:0] ra, logic rg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= valid;
    s_axis_tdata <= {6'd0, rg, ra, lg, la};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    odo.note_reading(valid, la, lg, ra, rg);
  endtask

  // Mostly small wheel motions from the last angles, with some wild jumps.
  task automatic random_readings(int count);
    logic [11:0] l, r;
    l = $urandom; r = $urandom;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        l = $urandom; r = $urandom;
      end else begin
        l += 12'($urandom_range(80) - 40);
        r += 12'($urandom_range(80) - 40);
      end
      send_reading($urandom_range(15) != 0, l, $urandom_range(9) != 0,
                   r, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Unprimed: invalid, one bad wheel, then priming.
    send_reading(0, 12'hfff, 1, 12'hfff, 1);
    send_reading(1, 12'd100, 0, 12'd200, 1);
    send_reading(1, 12'd100, 1, 12'd200, 0);
    send_reading(1, 12'd0, 1, 12'd0, 1);
    // Gains still zero: totals move, pose stays.
    send_reading(1, 12'hfff, 1, 12'd1, 1);
    drain();
    write_reg(ddo_pkg::CFG_METRES_PER_TICK, 64'hffff_ffff);
    write_reg(ddo_pkg::CFG_TURN_PER_TICK, 64'hffff_ffff);
    write_reg(ddo_pkg::CFG_START_X, 64'h8000_0000_0000_0000);
    write_reg(ddo_pkg::CFG_START_Y, 64'h7fff_ffff_ffff_ffff);
    write_reg(ddo_pkg::CFG_START_HEADING, 64'hffff_ffff);
    // Unwrap edges: exactly a half turn, just past it, both directions.
    send_reading(1, 12'd2047, 1, 12'd2048, 1);
    send_reading(1, 12'd4095, 1, 12'd0, 1);
    send_reading(1, 12'd2046, 1, 12'd2049, 1);
    send_reading(1, 12'd0, 1, 12'd4095, 1);
    send_reading(1, 12'd1, 0, 12'd5, 1);
    send_reading(1, 12'd7, 1, 12'd9, 0);
    send_reading(0, 12'd123, 1, 12'd456, 1);
    send_reading(1, 12'd7, 0, 12'd5, 0);
    drain();
    write_reg(ddo_pkg::CFG_METRES_PER_TICK, 64'd0);
    write_reg(ddo_pkg::CFG_TURN_PER_TICK, 64'd0);
    write_reg(ddo_pkg::CFG_START_HEADING, 64'h4000_0000);
    send_reading(1, 12'd100, 1, 12'd300, 1);
    send_reading(1, 12'd150, 1, 12'd250, 1);
    drain();

    send_idle_pct = 9; recv_idle_pct = 74;
    write_reg(ddo_pkg::CFG_METRES_PER_TICK, 64'(32'($urandom)));
    write_reg(ddo_pkg::CFG_TURN_PER_TICK, 64'(32'($urandom_range(1 << 24))));
    random_readings(370);
    drain();

    send_idle_pct = 74; recv_idle_pct = 9;
    write_reg(ddo_pkg::CFG_METRES_PER_TICK, 64'hffff_ffff);
    write_reg(ddo_pkg::CFG_TURN_PER_TICK, 64'(32'($urandom)));
    write_reg(ddo_pkg::CFG_START_X, {32'($urandom), 32'($urandom)});
    write_reg(ddo_pkg::CFG_START_Y, {32'($urandom), 32'($urandom)});
    write_reg(ddo_pkg::CFG_START_HEADING, 64'(32'($urandom)));
    random_readings(370);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(ddo_pkg::CFG_METRES_PER_TICK, 64'd1);
    write_reg(ddo_pkg::CFG_TURN_PER_TICK, 64'hffff_ffff);
    random_readings(370);
    drain();

    if (odo.errors == 0 && odo.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: differential_drive_odometry.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_sine_rom.sv
hw/rtl/ddo_datapath.sv
hw/rtl/ddo_ctrl.sv
hw/rtl/differential_drive_odometry.sv
tb/sv/tb_differential_drive_odometry.sv
